// File: sv/rbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared sizes, codes and control types of the red-black stencil solver.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int MAX_GRID = 64;
  localparam int COORD_W  = $clog2(MAX_GRID);
  localparam int AW       = 2 * COORD_W;
  localparam int DEPTH    = 1 << AW;
  localparam int NW       = COORD_W + 2;           // loop counters, may pass the edge
  localparam int XW       = (NW > 7) ? NW : 7;     // compare width for port values

  localparam int CELL_W = 24;
  localparam int ACC_W  = CELL_W + 2;
  localparam int ITER_W = 16;
  localparam int TOL_W  = 23;
  localparam int GS_W   = 7;
  localparam int ROW_W  = 6;
  localparam int OPC_W  = 2;
  localparam int CIDX_W = 2;
  localparam int CFG_W  = 23;

  typedef enum logic [OPC_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_GRID_SIZE = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_MAX_ITER  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_COPY,
    ST_ROW,
    ST_CELL,
    ST_ITER
  } state_t;

  // per-cell sequence: four neighbor reads, self read, finish
  typedef enum logic [2:0] {
    STP_UP,
    STP_LEFT,
    STP_RIGHT,
    STP_DOWN,
    STP_SELF,
    STP_FIN
  } step_t;

  typedef struct packed {
    logic [GS_W-1:0]   grid_size;
    logic [TOL_W-1:0]  tolerance;
    logic [ITER_W-1:0] max_iterations;
  } cfg_t;

  typedef struct packed {
    logic [AW-1:0]     rd_addr;
    logic              rd_new;
    logic              copy_rd;
    logic              wr_load;
    logic              acc_ld;
    logic              acc_add;
    logic              cell_fin;
    logic              max_clr;
    logic              swap;
    logic              rec;
    logic [ITER_W-1:0] it_val;
    logic              emit;
    logic              emit_rd;
    logic              rd_ok;
  } dp_cmd_t;

  typedef struct packed {
    logic gt_tol;
  } dp_stat_t;

  function automatic logic [AW-1:0] grid_addr(input logic [NW-1:0] r,
                                              input logic [NW-1:0] c);
    return {r[COORD_W-1:0], c[COORD_W-1:0]};
  endfunction

endpackage

// File: sv/rbs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_ctrl
// Sequencer: decodes items, walks copy, red and black sweeps, ends solves.
// ----------------------------------------------------------------------------
module rbs_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [rbs_pkg::OPC_W-1:0] in_opcode,
  input  logic [rbs_pkg::ROW_W-1:0] in_row,
  input  logic [rbs_pkg::ROW_W-1:0] in_col,
  input  rbs_pkg::cfg_t             cfg,
  input  rbs_pkg::dp_stat_t         stat,
  output rbs_pkg::dp_cmd_t          cmd
);
  import rbs_pkg::*;

  state_t             state_r, state_nxt;
  step_t              step_r, step_nxt;
  logic [NW-1:0]      i_r, i_nxt;
  logic [NW-1:0]      j_r, j_nxt;
  logic               color_r, color_nxt;
  logic [AW-1:0]      c_r, c_nxt;
  logic [ITER_W-1:0]  it_r, it_nxt;
  logic               rd_ok_r, rd_ok_nxt;

  logic               accept;
  logic               in_grid;
  logic [XW-1:0]      gs;
  logic [NW-1:0]      n;
  logic [NW-1:0]      row_start;
  logic [ITER_W-1:0]  cap;
  logic               stop;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign in_grid = (XW'(in_row) < XW'(MAX_GRID)) && (XW'(in_col) < XW'(MAX_GRID));

  always_comb begin
    gs = XW'(cfg.grid_size);
    if (gs < XW'(3)) begin
      n = NW'(3);
    end else if (gs > XW'(MAX_GRID)) begin
      n = NW'(MAX_GRID);
    end else begin
      n = NW'(gs);
    end
  end

  // red starts on odd columns of odd rows, black on even ones
  assign row_start = (i_r[0] ^ color_r) ? NW'(1) : NW'(2);
  assign cap  = (cfg.max_iterations == '0) ? ITER_W'(1) : cfg.max_iterations;
  assign stop = !stat.gt_tol || (({1'b0, it_r} + 17'd1) >= {1'b0, cap});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= STP_UP;
      i_r     <= '0;
      j_r     <= '0;
      color_r <= 1'b0;
      c_r     <= '0;
      it_r    <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      color_r <= color_nxt;
      c_r     <= c_nxt;
      it_r    <= it_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  // next state and counters
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    color_nxt = color_r;
    c_nxt     = c_r;
    it_nxt    = it_r;
    rd_ok_nxt = rd_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_READ: begin
              state_nxt = ST_RD;
              rd_ok_nxt = in_grid;
            end
            OP_SOLVE: begin
              state_nxt = ST_COPY;
              c_nxt     = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RD: state_nxt = ST_IDLE;
      ST_COPY: begin
        c_nxt = c_r + AW'(1);
        if (c_r == '1) begin
          state_nxt = ST_ROW;
          i_nxt     = NW'(1);
          color_nxt = 1'b0;
          it_nxt    = '0;
        end
      end
      ST_ROW: begin
        if (i_r + NW'(1) >= n) begin
          if (!color_r) begin
            color_nxt = 1'b1;
            i_nxt     = NW'(1);
          end else begin
            state_nxt = ST_ITER;
          end
        end else if (row_start + NW'(1) < n) begin
          j_nxt     = row_start;
          step_nxt  = STP_UP;
          state_nxt = ST_CELL;
        end else begin
          i_nxt = i_r + NW'(1);
        end
      end
      ST_CELL: begin
        if (step_r == STP_FIN) begin
          step_nxt = STP_UP;
          if (j_r + NW'(3) < n) begin
            j_nxt = j_r + NW'(2);
          end else begin
            i_nxt     = i_r + NW'(1);
            state_nxt = ST_ROW;
          end
        end else begin
          step_nxt = step_t'(step_r + 3'd1);
        end
      end
      ST_ITER: begin
        if (stop) begin
          state_nxt = ST_IDLE;
        end else begin
          it_nxt    = it_r + ITER_W'(1);
          i_nxt     = NW'(1);
          color_nxt = 1'b0;
          state_nxt = ST_ROW;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.rd_addr = grid_addr(NW'(in_row), NW'(in_col));
    cmd.it_val  = it_r + ITER_W'(1);
    cmd.rd_ok   = rd_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (op_t'(in_opcode))
            OP_LOAD: begin
              cmd.wr_load = in_grid;
              cmd.emit    = 1'b1;
            end
            OP_READ:  ;
            OP_SOLVE: ;
            default:  cmd.emit = 1'b1;
          endcase
        end
      end
      ST_RD: cmd.emit_rd = 1'b1;
      ST_COPY: begin
        cmd.rd_addr = c_r;
        cmd.copy_rd = 1'b1;
        cmd.max_clr = (c_r == '1);
      end
      ST_CELL: begin
        case (step_r)
          STP_UP: begin
            cmd.rd_addr = grid_addr(i_r - NW'(1), j_r);
            cmd.rd_new  = color_r;
          end
          STP_LEFT: begin
            cmd.rd_addr = grid_addr(i_r, j_r - NW'(1));
            cmd.rd_new  = color_r;
            cmd.acc_ld  = 1'b1;
          end
          STP_RIGHT: begin
            cmd.rd_addr = grid_addr(i_r, j_r + NW'(1));
            cmd.acc_add = 1'b1;
          end
          STP_DOWN: begin
            cmd.rd_addr = grid_addr(i_r + NW'(1), j_r);
            cmd.acc_add = 1'b1;
          end
          STP_SELF: begin
            cmd.rd_addr = grid_addr(i_r, j_r);
            cmd.acc_add = 1'b1;
          end
          STP_FIN: begin
            cmd.rd_addr  = grid_addr(i_r, j_r);
            cmd.cell_fin = 1'b1;
          end
          default: ;
        endcase
      end
      ST_ITER: begin
        cmd.swap = 1'b1;
        if (stop) begin
          cmd.rec  = 1'b1;
          cmd.emit = 1'b1;
        end else begin
          cmd.max_clr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_read_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_READ)) |=> (state_r == ST_RD))
    else $error("read item did not enter read wait");

  a_cell_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> ((i_r != '0) && (j_r != '0) &&
                              (i_r + NW'(1) < n) && (j_r + NW'(1) < n)))
    else $error("cell update outside the interior");

  a_copy_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY) |=> ((state_r == ST_COPY) || (state_r == ST_ROW)))
    else $error("copy pass left early");

endmodule

// File: sv/rbs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbs_dpath
// Two ping-pong grid banks, stencil accumulator, change tracking, results.
// ----------------------------------------------------------------------------
module rbs_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rbs_pkg::dp_cmd_t                  cmd,
  input  logic signed [rbs_pkg::CELL_W-1:0] in_cell_in,
  input  logic [rbs_pkg::TOL_W-1:0]         tolerance,
  output rbs_pkg::dp_stat_t                 stat,
  output logic                              out_valid,
  output logic signed [rbs_pkg::CELL_W-1:0] out_cell_out,
  output logic [rbs_pkg::ITER_W-1:0]        out_iterations,
  output logic                              out_converged,
  output logic [rbs_pkg::CELL_W-1:0]        out_last_diff
);
  import rbs_pkg::*;

  logic [CELL_W-1:0] mem0 [DEPTH];
  logic [CELL_W-1:0] mem1 [DEPTH];
  logic [CELL_W-1:0] m0_q, m1_q;

  logic              bank_r;          // physical bank holding the old grid
  logic              rd_sel_r;
  logic              copy_pend_r;
  logic [AW-1:0]     copy_addr_r;

  logic signed [ACC_W-1:0] acc_r;
  logic [CELL_W-1:0]       max_r;

  logic [ITER_W-1:0] iter_res_r, iter_res_nxt;
  logic              conv_r, conv_nxt;
  logic [CELL_W-1:0] final_r, final_nxt;

  logic              out_valid_r;
  logic [CELL_W-1:0] out_cell_r;
  logic [ITER_W-1:0] out_iter_r;
  logic              out_conv_r;
  logic [CELL_W-1:0] out_diff_r;

  logic [CELL_W-1:0]       rdata;
  logic [CELL_W-1:0]       q;
  logic signed [CELL_W:0]  d;
  logic [CELL_W-1:0]       absd;
  logic                    we_any, wphys;
  logic [AW-1:0]           waddr;
  logic [CELL_W-1:0]       wdata;

  assign rdata = rd_sel_r ? m1_q : m0_q;
  assign q     = acc_r[ACC_W-1:2];   // floor divide by four
  assign d     = $signed({q[CELL_W-1], q}) - $signed({rdata[CELL_W-1], rdata});
  assign absd  = d[CELL_W] ? CELL_W'(-d) : d[CELL_W-1:0];

  assign stat.gt_tol = (max_r > {1'b0, tolerance});

  always_comb begin
    we_any = 1'b0;
    wphys  = bank_r;
    waddr  = cmd.rd_addr;
    wdata  = in_cell_in;
    if (copy_pend_r) begin
      we_any = 1'b1;
      wphys  = ~bank_r;
      waddr  = copy_addr_r;
      wdata  = rdata;
    end else if (cmd.wr_load) begin
      we_any = 1'b1;
    end else if (cmd.cell_fin) begin
      we_any = 1'b1;
      wphys  = ~bank_r;
      wdata  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (we_any && !wphys) begin
      mem0[waddr] <= wdata;
    end
    m0_q <= mem0[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_any && wphys) begin
      mem1[waddr] <= wdata;
    end
    m1_q <= mem1[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r      <= 1'b0;
      copy_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.swap) begin
        bank_r <= ~bank_r;
      end
      copy_pend_r <= cmd.copy_rd;
      out_valid_r <= cmd.emit || cmd.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_sel_r    <= bank_r ^ cmd.rd_new;
    copy_addr_r <= cmd.rd_addr;
    if (cmd.acc_ld) begin
      acc_r <= ACC_W'($signed(rdata));
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'($signed(rdata));
    end
    if (cmd.max_clr) begin
      max_r <= '0;
    end else if (cmd.cell_fin && (absd > max_r)) begin
      max_r <= absd;
    end
  end

  always_comb begin
    iter_res_nxt = iter_res_r;
    conv_nxt     = conv_r;
    final_nxt    = final_r;
    if (cmd.rec) begin
      iter_res_nxt = cmd.it_val;
      conv_nxt     = !stat.gt_tol;
      final_nxt    = max_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_res_r <= '0;
      conv_r     <= 1'b0;
      final_r    <= '0;
    end else begin
      iter_res_r <= iter_res_nxt;
      conv_r     <= conv_nxt;
      final_r    <= final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.emit_rd) begin
      out_cell_r <= (cmd.emit_rd && cmd.rd_ok) ? rdata : '0;
      out_iter_r <= iter_res_nxt;
      out_conv_r <= conv_nxt;
      out_diff_r <= final_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = out_cell_r;
  assign out_iterations = out_iter_r;
  assign out_converged  = out_conv_r;
  assign out_last_diff  = out_diff_r;

  a_copy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    copy_pend_r |-> !(cmd.wr_load || cmd.cell_fin))
    else $error("grid write collides with copy pass");

  a_rec_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec |=> (out_valid && (out_iterations == $past(cmd.it_val))))
    else $error("solve result not delivered");

endmodule

// File: sv/red_black_stencil_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_black_stencil_solver
// Red-black Gauss-Seidel Poisson solver over a fixed-point square grid.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  item    | in_opcode in_row in_col in_cell_in      | start & !busy
//  result  | out_cell_out out_iterations             | out_valid, 1 cycle
//          | out_converged out_last_diff             |
//  config  | cfg_index cfg_wdata                     | cfg_valid & cfg_ready
//
// Load and unused opcodes: accepted every cycle, result the next cycle.
// Read: busy during the registered RAM read, then the result is registered.
// Solve: bank copy of all 4096 cells, then per iteration a red and a black sweep,
// reads one at a time on the single RAM read port; result in the next cycle.
// Synchronous active-low reset; the result side has no stall.
module red_black_stencil_solver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rbs_pkg::OPC_W-1:0]         in_opcode,
  input  logic [rbs_pkg::ROW_W-1:0]         in_row,
  input  logic [rbs_pkg::ROW_W-1:0]         in_col,
  input  logic signed [rbs_pkg::CELL_W-1:0] in_cell_in,
  output logic                              out_valid,
  output logic signed [rbs_pkg::CELL_W-1:0] out_cell_out,
  output logic [rbs_pkg::ITER_W-1:0]        out_iterations,
  output logic                              out_converged,
  output logic [rbs_pkg::CELL_W-1:0]        out_last_diff,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rbs_pkg::CFG_W-1:0]         cfg_wdata
);
  import rbs_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_SIZE: cfg_nxt.grid_size      = cfg_wdata[GS_W-1:0];
        CFG_TOLERANCE: cfg_nxt.tolerance      = cfg_wdata[TOL_W-1:0];
        CFG_MAX_ITER:  cfg_nxt.max_iterations = cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size      <= GS_W'(MAX_GRID);
      cfg_r.tolerance      <= TOL_W'(1);
      cfg_r.max_iterations <= '1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_row    (in_row),
    .in_col    (in_col),
    .cfg       (cfg_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbs_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_cell_in     (in_cell_in),
    .tolerance      (cfg_r.tolerance),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_cell_out   (out_cell_out),
    .out_iterations (out_iterations),
    .out_converged  (out_converged),
    .out_last_diff  (out_last_diff)
  );

endmodule
